FILE: design/buddy_block_allocator_macros.svh
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// check a property on every rising edge outside reset
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on every rising edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [1:0] STATUS_BAD_REL = 2'd2;

  typedef struct packed {
    logic        command;
    logic [10:0] request_size;
    logic [9:0]  block_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  granted_address;
    logic [10:0] granted_size;
  } result_t;

endpackage

FILE: design/buddy_block_allocator.sv
`timescale 1ns / 1ps

// channel   | ports                    | handshake
// ----------+--------------------------+----------------------------------
// command   | start, busy, cmd_i       | beat taken when start && !busy
// result    | done_o, result_o         | one-cycle strobe, no back-pressure
//
// After reset a clearing pass writes every table entry, with busy high.
// Allocate: a scan of every slot through the single read port, then one write
// per halving plus a final write that marks the block used.
// Release: a lookup read of the block's entry, then per buddy check a read and one write;
// a block that reaches the top level ends in one write.
// A bad release address answers in the next cycle without raising busy.
// One beat in flight at a time; the result register frees the block at once.

module buddy_block_allocator #(
  parameter int MEMORY_BYTES    = 1024,
  parameter int MIN_BLOCK_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bba_pkg::cmd_t    cmd_i,
  output logic             done_o,
  output bba_pkg::result_t result_o
);

  localparam int SLOTS = MEMORY_BYTES / MIN_BLOCK_BYTES;
  localparam int TOP   = $clog2(SLOTS);
  localparam int LW    = (TOP < 1) ? 1 : $clog2(TOP + 1);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MSH   = $clog2(MIN_BLOCK_BYTES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_RREAD = 4'd4;
  localparam logic [3:0] S_RCHK  = 4'd5;
  localparam logic [3:0] S_MREAD = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;

  typedef struct packed {
    logic          valid;
    logic          free;
    logic [LW-1:0] level;
  } ent_t;

  ent_t mem [SLOTS];
  ent_t rdata_q;
  logic [SW-1:0] raddr;
  logic          we;
  logic [SW-1:0] waddr;
  ent_t          wdata;

  logic [3:0]    state_q, state_d;
  logic [SW:0]   cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d;
  logic [SW-1:0] best_q, best_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [LW-1:0] need_q, need_d;
  logic          fit_q, fit_d;
  logic          done_q, done_d;
  bba_pkg::result_t res_q, res_d;

  logic [LW-1:0] need_c;
  logic          fit_c;
  logic [SW-1:0] bit_c;
  logic [31:0]   addr_c;
  logic [31:0]   size_c;
  logic [31:0]   rel_slot_c;
  logic          rel_bad_c;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    need_c = '0;
    fit_c  = 1'b0;
    for (int l = TOP; l >= 0; l--) begin
      if (32'(cmd_i.request_size) <= (32'(MIN_BLOCK_BYTES) << l)) begin
        need_c = LW'(l);
        fit_c  = 1'b1;
      end
    end
  end

  assign rel_slot_c = 32'(cmd_i.block_address) >> MSH;
  assign rel_bad_c  = ((32'(cmd_i.block_address) & 32'(MIN_BLOCK_BYTES - 1)) != 32'd0) ||
                      (rel_slot_c >= 32'(SLOTS));
  assign bit_c      = SW'(1) << lv_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    found_d = found_q;
    best_d  = best_q;
    lv_d    = lv_q;
    need_d  = need_q;
    fit_d   = fit_q;
    done_d  = 1'b0;
    res_d   = res_q;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    addr_c  = 32'(best_q) << MSH;
    size_c  = 32'(MIN_BLOCK_BYTES) << lv_q;

    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt_q[SW-1:0];
        if (cnt_q == '0) begin
          wdata = '{valid: 1'b1, free: 1'b1, level: LW'(TOP)};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (SW + 1)'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (cmd_i.command == bba_pkg::CMD_ALLOC) begin
            state_d = S_SCAN;
            cnt_d   = '0;
            found_d = 1'b0;
            need_d  = need_c;
            fit_d   = fit_c;
          end else if (rel_bad_c) begin
            done_d  = 1'b1;
            res_d   = '{status: bba_pkg::STATUS_BAD_REL,
                        granted_address: cmd_i.block_address, granted_size: '0};
          end else begin
            state_d = S_RREAD;
            best_d  = rel_slot_c[SW-1:0];
            res_d.granted_address = cmd_i.block_address;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && rdata_q.valid && rdata_q.free && rdata_q.level >= need_q &&
            (!found_q || rdata_q.level < lv_q)) begin
          found_d = 1'b1;
          best_d  = cnt_q[SW-1:0] - 1'b1;
          lv_d    = rdata_q.level;
        end
        if (cnt_q < (SW + 1)'(SLOTS)) begin
          raddr  = cnt_q[SW-1:0];
          pend_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else if (!pend_q) begin
          if (found_q && fit_q) begin
            state_d = S_SPLIT;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
            res_d   = '{status: bba_pkg::STATUS_NO_FIT, granted_address: '0,
                        granted_size: '0};
          end
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (lv_q > need_q) begin
          lv_d  = lv_q - 1'b1;
          waddr = best_q | (SW'(1) << lv_d);
          wdata = '{valid: 1'b1, free: 1'b1, level: lv_d};
        end else begin
          waddr   = best_q;
          wdata   = '{valid: 1'b1, free: 1'b0, level: lv_q};
          state_d = S_IDLE;
          done_d  = 1'b1;
          res_d   = '{status: bba_pkg::STATUS_OK, granted_address: addr_c[9:0],
                      granted_size: size_c[10:0]};
        end
      end
      S_RREAD: begin
        raddr   = best_q;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (!rdata_q.valid || rdata_q.free) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          res_d.status       = bba_pkg::STATUS_BAD_REL;
          res_d.granted_size = '0;
        end else begin
          lv_d    = rdata_q.level;
          state_d = S_MREAD;
        end
      end
      S_MREAD: begin
        if (lv_q == LW'(TOP)) begin
          we      = 1'b1;
          waddr   = best_q;
          wdata   = '{valid: 1'b1, free: 1'b1, level: lv_q};
          state_d = S_IDLE;
          done_d  = 1'b1;
          res_d   = '{status: bba_pkg::STATUS_OK, granted_address: addr_c[9:0],
                      granted_size: size_c[10:0]};
        end else begin
          raddr   = best_q ^ bit_c;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        we = 1'b1;
        if (rdata_q.valid && rdata_q.free && rdata_q.level == lv_q) begin
          waddr   = best_q | bit_c;
          best_d  = best_q & ~bit_c;
          lv_d    = lv_q + 1'b1;
          state_d = S_MREAD;
        end else begin
          waddr   = best_q;
          wdata   = '{valid: 1'b1, free: 1'b1, level: lv_q};
          state_d = S_IDLE;
          done_d  = 1'b1;
          res_d   = '{status: bba_pkg::STATUS_OK, granted_address: addr_c[9:0],
                      granted_size: size_c[10:0]};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    best_q  <= best_d;
    lv_q    <= lv_d;
    need_q  <= need_d;
    fit_q   <= fit_d;
    res_q   <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: design/bba_checker.sv
`timescale 1ns / 1ps
`include "buddy_block_allocator_macros.svh"

module bba_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input bba_pkg::result_t result_o
);

  `BBA_ASSERT(a_accept_busy, start && !busy |=> busy || done_o, "accepted beat left no trace")
  `BBA_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `BBA_ASSERT(a_idle_quiet, !start && !busy |=> !done_o, "result strobe without a beat")
  `BBA_ASSERT(a_err_size, done_o && result_o.status != bba_pkg::STATUS_OK |-> result_o.granted_size == '0, "error result with nonzero size")
  `BBA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "result strobe during reset")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
